// ===== rtl/core/y86fd_pkg.sv =====
`timescale 1ns / 1ps

package y86fd_pkg;

    // Memory size in bytes; a pc at or beyond it is an address fault
    localparam int MEM_BYTES = 4096;
    localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);

    // Opcode nibble of the first instruction byte
    typedef enum logic [3:0] {
        I_HALT    = 4'h0,
        I_NOP     = 4'h1,
        I_RRMOVQ  = 4'h2,
        I_IRMOVQ  = 4'h3,
        I_RMMOVQ  = 4'h4,
        I_MRMOVQ  = 4'h5,
        I_OPQ     = 4'h6,
        I_JXX     = 4'h7,
        I_CALL    = 4'h8,
        I_RET     = 4'h9,
        I_PUSHQ   = 4'hA,
        I_POPQ    = 4'hB,
        I_IOTRAP  = 4'hC,
        I_INVALID = 4'hF
    } t_icode;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ADR = 2'd1;
    localparam logic [1:0] ST_INS = 2'd2;

    // Register specifier meaning "no register"
    localparam logic [3:0] NO_REG = 4'hF;

    // Function and register limits
    localparam logic [3:0] FN_NONE     = 4'd0;
    localparam logic [3:0] FN_MAX_COND = 4'd6;
    localparam logic [3:0] FN_MAX_OPQ  = 4'd3;
    localparam logic [3:0] FN_MAX_TRAP = 4'd5;
    localparam logic [3:0] REG_MAX_PP  = 4'd7;

    // Instruction lengths in bytes
    localparam logic [3:0] LEN_BYTE  = 4'd1;
    localparam logic [3:0] LEN_REG   = 4'd2;
    localparam logic [3:0] LEN_DEST  = 4'd9;
    localparam logic [3:0] LEN_IMM   = 4'd10;

    // Decoded instruction as held in the result register
    typedef struct packed {
        t_icode      icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] constant_value;
        logic [12:0] next_pc;
        logic [1:0]  status;
    } t_result;

    // Length of an instruction from its opcode
    function automatic logic [3:0] ins_length(input t_icode ic);
        logic [3:0] len;
        unique case (ic) inside
            I_RRMOVQ, I_OPQ, I_PUSHQ, I_POPQ: len = LEN_REG;
            I_IRMOVQ, I_RMMOVQ, I_MRMOVQ:     len = LEN_IMM;
            I_JXX, I_CALL:                    len = LEN_DEST;
            default:                          len = LEN_BYTE;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/y86_instruction_fetch_decode_core.sv =====
`timescale 1ns / 1ps

// Y86-64 fetch decode: each transaction carries a pc and the ten bytes at it and
// returns one decoded instruction (opcode, function, registers, constant, next pc)
// or a fault status. The block is two register stages deep: the input register
// and the result register with the decode logic between them. A transaction moves
// from the input register into the result register, and is presented on the output,
// when the result register is empty or being taken; one transaction can be accepted
// every cycle while the output is taken. A result waiting on the output does not
// stop an empty input register from filling; once both registers hold a
// transaction the input stalls until the output is taken. Memory size is MEM_BYTES
// in the package.
module y86_instruction_fetch_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_pc,
    input  logic [63:0] i_head_bytes,
    input  logic [15:0] i_tail_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_icode,
    output logic [3:0]  o_ifun,
    output logic [3:0]  o_reg_a,
    output logic [3:0]  o_reg_b,
    output logic [63:0] o_constant_value,
    output logic [12:0] o_next_pc,
    output logic [1:0]  o_status
);

    logic                r_s1_valid;
    logic [15:0]         r_pc;
    logic [63:0]         r_head;
    logic [15:0]         r_tail;
    logic                r_out_valid;
    y86fd_pkg::t_result  r_res;
    y86fd_pkg::t_result  n_res;

    logic                s2_free;
    logic                s1_adv;

    y86fd_pkg::t_icode   ic;
    logic [3:0]          fn;
    logic [3:0]          ra;
    logic [3:0]          rb;
    logic [3:0]          len;
    logic [16:0]         pc_end;
    logic                ok;

    // Stage handshake: advance when the next stage is empty or draining
    assign s2_free    = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s2_free;

    // Split the fetched window into fields
    assign ic     = y86fd_pkg::t_icode'(r_head[7:4]);
    assign fn     = r_head[3:0];
    assign ra     = r_head[15:12];
    assign rb     = r_head[11:8];
    assign len    = y86fd_pkg::ins_length(ic);
    assign pc_end = {1'b0, r_pc} + {13'd0, len};

    // Check function and register limits per opcode
    always_comb begin
        unique case (ic) inside
            y86fd_pkg::I_HALT, y86fd_pkg::I_NOP, y86fd_pkg::I_RET,
            y86fd_pkg::I_RMMOVQ, y86fd_pkg::I_MRMOVQ, y86fd_pkg::I_CALL:
                ok = (fn == y86fd_pkg::FN_NONE);
            y86fd_pkg::I_RRMOVQ:
                ok = (fn <= y86fd_pkg::FN_MAX_COND) && (ra != y86fd_pkg::NO_REG)
                     && (rb != y86fd_pkg::NO_REG);
            y86fd_pkg::I_IRMOVQ:
                ok = (fn == y86fd_pkg::FN_NONE) && (ra == y86fd_pkg::NO_REG);
            y86fd_pkg::I_OPQ:
                ok = (fn <= y86fd_pkg::FN_MAX_OPQ);
            y86fd_pkg::I_JXX:
                ok = (fn <= y86fd_pkg::FN_MAX_COND);
            y86fd_pkg::I_PUSHQ, y86fd_pkg::I_POPQ:
                ok = (fn == y86fd_pkg::FN_NONE) && (ra <= y86fd_pkg::REG_MAX_PP)
                     && (rb == y86fd_pkg::NO_REG);
            y86fd_pkg::I_IOTRAP:
                ok = (fn <= y86fd_pkg::FN_MAX_TRAP);
            default:
                ok = 1'b0;
        endcase
    end

    // Build the result: faults first, then the fields the opcode uses
    always_comb begin
        n_res.icode          = y86fd_pkg::I_INVALID;
        n_res.ifun           = fn;
        n_res.reg_a          = y86fd_pkg::NO_REG;
        n_res.reg_b          = y86fd_pkg::NO_REG;
        n_res.constant_value = '0;
        n_res.next_pc        = '0;
        n_res.status         = y86fd_pkg::ST_OK;
        if ({1'b0, r_pc} >= y86fd_pkg::MEM_LIMIT) begin
            n_res.ifun   = y86fd_pkg::FN_NONE;
            n_res.status = y86fd_pkg::ST_ADR;
        end else if (len > y86fd_pkg::LEN_BYTE && pc_end > y86fd_pkg::MEM_LIMIT) begin
            n_res.status = y86fd_pkg::ST_ADR;
        end else if (!ok) begin
            n_res.status = y86fd_pkg::ST_INS;
        end else begin
            n_res.icode   = ic;
            n_res.next_pc = pc_end[12:0];
            unique case (ic) inside
                y86fd_pkg::I_RRMOVQ, y86fd_pkg::I_OPQ,
                y86fd_pkg::I_PUSHQ, y86fd_pkg::I_POPQ: begin
                    n_res.reg_a = ra;
                    n_res.reg_b = rb;
                end
                y86fd_pkg::I_IRMOVQ, y86fd_pkg::I_RMMOVQ, y86fd_pkg::I_MRMOVQ: begin
                    n_res.reg_a          = ra;
                    n_res.reg_b          = rb;
                    n_res.constant_value = {r_tail, r_head[63:16]};
                end
                y86fd_pkg::I_JXX, y86fd_pkg::I_CALL: begin
                    n_res.constant_value = {r_tail[7:0], r_head[63:8]};
                end
                default: begin
                    n_res.constant_value = '0;
                end
            endcase
        end
    end

    // Hold valid flags; advance payload registers on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_pc   <= i_pc;
            r_head <= i_head_bytes;
            r_tail <= i_tail_bytes;
        end
        if (s1_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_icode          = r_res.icode;
    assign o_ifun           = r_res.ifun;
    assign o_reg_a          = r_res.reg_a;
    assign o_reg_b          = r_res.reg_b;
    assign o_constant_value = r_res.constant_value;
    assign o_next_pc        = r_res.next_pc;
    assign o_status         = r_res.status;

    // A good instruction never carries the invalid opcode
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status == y86fd_pkg::ST_OK)
            |-> (r_res.icode != y86fd_pkg::I_INVALID))
        else $error("ok status with invalid opcode");

    // A fault clears every field but the function nibble
    a_fault_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != y86fd_pkg::ST_OK)
            |-> (r_res.icode == y86fd_pkg::I_INVALID && r_res.reg_a == y86fd_pkg::NO_REG
                 && r_res.reg_b == y86fd_pkg::NO_REG && r_res.constant_value == '0
                 && r_res.next_pc == '0))
        else $error("fault result carries decoded fields");

    // Jump and call carry no registers
    a_jump_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status == y86fd_pkg::ST_OK
         && (r_res.icode == y86fd_pkg::I_JXX || r_res.icode == y86fd_pkg::I_CALL))
            |-> (r_res.reg_a == y86fd_pkg::NO_REG && r_res.reg_b == y86fd_pkg::NO_REG))
        else $error("jump or call with register specifiers");

    // A result appears only from a filled input register
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result without a pending transaction");

endmodule
